FILE: rtl/qdmi_pkg.sv
`default_nettype none

package qdmi_pkg;

   // request commands
   localparam logic [1:0] CMD_EDGE_A = 2'd0;
   localparam logic [1:0] CMD_EDGE_B = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   // pending step codes
   localparam logic [1:0] STEP_NONE  = 2'd0;
   localparam logic [1:0] STEP_PLUS  = 2'd1;
   localparam logic [1:0] STEP_MINUS = 2'd3;

   localparam int LENGTH_W = 9;
   localparam int INDEX_W  = 8;

   typedef struct packed {
      logic [1:0] command;
      logic       level;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] menu_index;
      logic               moved;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/quadrature_detent_menu_index.sv
`default_nettype none

// Quadrature decoder that turns encoder edges into detent steps of a menu index.
// Request channel (req_valid/req_ready/req_data): one event per request, an edge
// on phase A or B carrying the new pin level, or an update tick that consumes
// the pending step. Response channel (rsp_valid/rsp_ready/rsp_data): exactly
// one response per request with the menu index after that request and a flag
// set when the index changed.
// Configuration (csr_valid/csr_ready/csr_data): the menu length, written while
// no request is in flight; csr_ready is always high.
// An accepted request is loaded into the input register; the state update and
// response register load from it once the response register is free. A request
// can be accepted every cycle while rsp_ready is high; the rate is one request
// per cycle, set by the single state update path between those two registers.
// When rsp_ready is low the response register holds, the input register fills,
// and req_ready drops until the response is taken.
// Reset clears the pin levels, pending step, step counts and index, and sets
// the menu length to 1; both channels come up empty.
module quadrature_detent_menu_index #(
   parameter int MAX_ENTRIES     = 256,
   parameter int STEPS_PER_NOTCH = 4
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  qdmi_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output qdmi_pkg::rsp_type          rsp_data,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [qdmi_pkg::LENGTH_W-1:0] csr_data
);
   import qdmi_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
   localparam int LEN_W = (LENGTH_W > IDX_W + 1) ? LENGTH_W : IDX_W + 1;
   localparam int CNT_W = $clog2(STEPS_PER_NOTCH + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] NOTCH   = CNT_W'(STEPS_PER_NOTCH);

   logic [LENGTH_W-1:0] length_ff;
   req_type             s1_ff;
   logic                s1_valid_ff;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff;
   logic                a_ff, a_in;
   logic                b_ff, b_in;
   logic [1:0]          pend_ff, pend_in;
   logic [CNT_W-1:0]    cw_ff, cw_in;
   logic [CNT_W-1:0]    ccw_ff, ccw_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [LEN_W-1:0]    len_wide;
   logic [LEN_W-1:0]    len_clamped;
   logic [IDX_W-1:0]    len_m1;
   logic                advance;

   // handshake
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // effective menu length, clamped to 1..MAX_ENTRIES
   always_comb begin
      len_wide = LEN_W'(length_ff);
      if (len_wide == '0) begin
         len_clamped = LEN_W'(1);
      end else if (len_wide > MAX_LEN) begin
         len_clamped = MAX_LEN;
      end else begin
         len_clamped = len_wide;
      end
      len_m1 = IDX_W'(len_clamped - LEN_W'(1));
   end

   // state update for the request in the input register
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      pend_in = pend_ff;
      cw_in   = cw_ff;
      ccw_in  = ccw_ff;
      idx_in  = idx_ff;
      unique case (s1_ff.command)
         CMD_EDGE_A: begin
            a_in    = s1_ff.level;
            pend_in = (s1_ff.level != b_ff) ? STEP_PLUS : STEP_MINUS;
         end
         CMD_EDGE_B: begin
            b_in    = s1_ff.level;
            pend_in = (a_ff == s1_ff.level) ? STEP_PLUS : STEP_MINUS;
         end
         CMD_TICK: begin
            if (pend_ff != STEP_NONE) begin
               if (pend_ff == STEP_MINUS) begin
                  cw_in  = cw_ff + CNT_W'(1);
                  ccw_in = '0;
               end else begin
                  ccw_in = ccw_ff + CNT_W'(1);
                  cw_in  = '0;
               end
               pend_in = STEP_NONE;
               // clockwise notch steps down, counter-clockwise steps up
               if (cw_in == NOTCH) begin
                  cw_in = '0;
                  if (idx_ff == '0 || idx_ff > len_m1) begin
                     idx_in = len_m1;
                  end else begin
                     idx_in = idx_ff - IDX_W'(1);
                  end
               end else if (ccw_in == NOTCH) begin
                  ccw_in = '0;
                  if (idx_ff >= len_m1) begin
                     idx_in = '0;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= LENGTH_W'(1);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         a_ff         <= 1'b0;
         b_ff         <= 1'b0;
         pend_ff      <= STEP_NONE;
         cw_ff        <= '0;
         ccw_ff       <= '0;
         idx_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            length_ff <= csr_data;
         end
         if (req_valid && req_ready) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            a_ff         <= a_in;
            b_ff         <= b_in;
            pend_ff      <= pend_in;
            cw_ff        <= cw_in;
            ccw_ff       <= ccw_in;
            idx_ff       <= idx_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff <= req_data;
      end
      if (advance) begin
         rsp_ff.menu_index <= INDEX_W'(idx_in);
         rsp_ff.moved      <= (idx_in != idx_ff);
      end
   end

   // checks
   a_counts_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cw_ff != '0 && ccw_ff != '0))
      else $error("both step counts nonzero");

   a_counts_below_notch: assert property (@(posedge clock) disable iff (reset)
      cw_ff < NOTCH && ccw_ff < NOTCH)
      else $error("step count reached a notch without clearing");

   a_tick_clears_pending: assert property (@(posedge clock) disable iff (reset)
      advance && s1_ff.command == CMD_TICK |=> pend_ff == STEP_NONE)
      else $error("pending step survived a tick");

   a_move_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      advance && s1_ff.command != CMD_TICK |=> !rsp_ff.moved)
      else $error("index moved on an edge request");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while both stages are full");

endmodule

`default_nettype wire
